FILE: design/sstf_pkg.sv
// Shared types and constants of the shortest-seek-first scheduler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sstf_pkg;

  localparam int MAX_REQUESTS = 64;
  localparam int TRACK_BITS   = 12;
  localparam int IDX_BITS     = $clog2(MAX_REQUESTS);
  localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);
  localparam int TOTAL_BITS   = 18;
  localparam int ADDR_BITS    = 3;
  localparam int DATA_BITS    = 32;

  localparam logic REG_HEAD_START = 1'b0;

  typedef struct packed {
    logic [TRACK_BITS-1:0] track;
    logic                  last_request;
  } req_word_t;

  typedef struct packed {
    logic [TRACK_BITS-1:0] served_track;
    logic [TRACK_BITS-1:0] step_seek;
    logic [TOTAL_BITS-1:0] total_seek;
    logic                  overflow;
    logic                  last_result;
  } res_word_t;

  typedef struct packed {
    logic                clear;
    logic                sample_valid;
    logic [IDX_BITS-1:0] sample_idx;
  } scan_ctl_t;

endpackage

FILE: design/sstf_store.sv
// Request store: one write port and one registered read port.
// Depends on sstf_pkg for depth and width.
`timescale 1ns / 1ps

module sstf_store (
  input  logic                              clk,
  input  logic                              we,
  input  logic [sstf_pkg::IDX_BITS-1:0]     waddr,
  input  logic [sstf_pkg::TRACK_BITS-1:0]   wdata,
  input  logic [sstf_pkg::IDX_BITS-1:0]     raddr,
  output logic [sstf_pkg::TRACK_BITS-1:0]   rdata
);

  logic [sstf_pkg::TRACK_BITS-1:0] mem [sstf_pkg::MAX_REQUESTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sstf_dist_unit.sv
// Shared distance and compare unit: takes one stored track per cycle and
// keeps the nearest one to the head seen in the current pass.
// Depends on sstf_pkg for widths and the scan control word.
`timescale 1ns / 1ps

module sstf_dist_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  sstf_pkg::scan_ctl_t               ctl,
  input  logic [sstf_pkg::TRACK_BITS-1:0]   sample_track,
  input  logic [sstf_pkg::TRACK_BITS-1:0]   head,
  output logic [sstf_pkg::TRACK_BITS-1:0]   best_dist,
  output logic [sstf_pkg::TRACK_BITS-1:0]   best_track,
  output logic [sstf_pkg::IDX_BITS-1:0]     best_idx
);

  logic                            found;
  logic [sstf_pkg::TRACK_BITS-1:0] gap;
  logic                            take;

  always_comb begin
    gap  = (sample_track >= head) ? (sample_track - head) : (head - sample_track);
    take = ctl.sample_valid && (!found || (gap < best_dist));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      best_dist  <= gap;
      best_track <= sample_track;
      best_idx   <= ctl.sample_idx;
    end
  end

endmodule

FILE: design/shortest_seek_first_scheduler_top.sv
// Top level of the shortest-seek-first scheduler: sequencer, served marks,
// configuration port and result register. Uses sstf_pkg, sstf_store and
// sstf_dist_unit.
//
// Usage: a request word is taken at a clock edge where start is high and busy
// is low. Words without last_request are stored; beyond 64 stored words a
// request is dropped and the batch is marked as overflowed.
// The word with last_request starts serving the stored batch of n requests
// from the head_start register. Each result needs one scan of the store
// through its single read port and the shared distance unit. Busy stays
// high while serving. Each result word is shown for one cycle with
// result_strobe high; the receiver cannot hold it off. The final result of
// a batch has last_result set, and the block takes new words again in the
// cycle it appears. head_start is written through the APB port at any
// address with paddr[2] low (0 to 3); the user must write it only while the
// block is idle, which the block itself does not enforce. Synchronous reset
// empties the batch, clears head_start and drops any result in flight; the
// store contents need no clearing.
`timescale 1ns / 1ps

module shortest_seek_first_scheduler_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  sstf_pkg::req_word_t                request,
  output logic                               result_strobe,
  output sstf_pkg::res_word_t                result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sstf_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [sstf_pkg::DATA_BITS-1:0]     pwdata,
  output logic [sstf_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                          state;
  logic [sstf_pkg::TRACK_BITS-1:0]     head_start;
  logic [sstf_pkg::TRACK_BITS-1:0]     head;
  logic [sstf_pkg::CNT_BITS-1:0]       count;
  logic [sstf_pkg::CNT_BITS-1:0]       rd_idx;
  logic [sstf_pkg::CNT_BITS-1:0]       pass;
  logic                                ovf;
  logic [sstf_pkg::MAX_REQUESTS-1:0]   served;
  logic [sstf_pkg::TOTAL_BITS-1:0]     total;
  logic [sstf_pkg::TOTAL_BITS-1:0]     total_next;
  logic [sstf_pkg::TOTAL_BITS:0]       total_sum;
  logic                                rd_valid;
  logic [sstf_pkg::IDX_BITS-1:0]       rd_slot;

  logic                                store_we;
  logic [sstf_pkg::TRACK_BITS-1:0]     store_rdata;
  logic [sstf_pkg::TRACK_BITS-1:0]     best_dist;
  logic [sstf_pkg::TRACK_BITS-1:0]     best_track;
  logic [sstf_pkg::IDX_BITS-1:0]       best_idx;
  logic                                cfg_we;
  logic                                last_pass;
  sstf_pkg::scan_ctl_t                 ctl;

  always_comb begin
    busy      = (state != S_IDLE);
    pready    = 1'b1;
    cfg_we    = psel && penable && pwrite && (paddr[2] == sstf_pkg::REG_HEAD_START);
    prdata    = (paddr[2] == sstf_pkg::REG_HEAD_START) ?
                {{(sstf_pkg::DATA_BITS-sstf_pkg::TRACK_BITS){1'b0}}, head_start} : '0;
    store_we  = (state == S_IDLE) && start &&
                (count != sstf_pkg::CNT_BITS'(sstf_pkg::MAX_REQUESTS));
    last_pass = ((pass + sstf_pkg::CNT_BITS'(1)) == count);
    total_sum = {1'b0, total} +
                {{(sstf_pkg::TOTAL_BITS+1-sstf_pkg::TRACK_BITS){1'b0}}, best_dist};
    total_next = total_sum[sstf_pkg::TOTAL_BITS] ? '1 : total_sum[sstf_pkg::TOTAL_BITS-1:0];
    ctl.clear        = (state != S_SCAN);
    ctl.sample_valid = rd_valid && !served[rd_slot];
    ctl.sample_idx   = rd_slot;
  end

  sstf_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[sstf_pkg::IDX_BITS-1:0]),
    .wdata (request.track),
    .raddr (rd_idx[sstf_pkg::IDX_BITS-1:0]),
    .rdata (store_rdata)
  );

  sstf_dist_unit u_dist (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sample_track (store_rdata),
    .head         (head),
    .best_dist    (best_dist),
    .best_track   (best_track),
    .best_idx     (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head_start    <= '0;
      head          <= '0;
      count         <= '0;
      rd_idx        <= '0;
      pass          <= '0;
      ovf           <= 1'b0;
      served        <= '0;
      total         <= '0;
      rd_valid      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == S_EMIT);
      rd_valid      <= (state == S_SCAN) && (rd_idx != count);
      if (cfg_we) begin
        head_start <= pwdata[sstf_pkg::TRACK_BITS-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (store_we) begin
              count <= count + sstf_pkg::CNT_BITS'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (request.last_request) begin
              state  <= S_SCAN;
              head   <= head_start;
              pass   <= '0;
              rd_idx <= '0;
              total  <= '0;
            end
          end
        end
        S_SCAN: begin
          rd_slot  <= rd_idx[sstf_pkg::IDX_BITS-1:0];
          if (rd_idx != count) begin
            rd_idx <= rd_idx + sstf_pkg::CNT_BITS'(1);
          end else if (!rd_valid) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          head                 <= best_track;
          total                <= total_next;
          result.served_track  <= best_track;
          result.step_seek     <= best_dist;
          result.total_seek    <= total_next;
          result.overflow      <= ovf;
          result.last_result   <= last_pass;
          if (last_pass) begin
            state  <= S_IDLE;
            count  <= '0;
            ovf    <= 1'b0;
            served <= '0;
          end else begin
            served[best_idx] <= 1'b1;
            state  <= S_SCAN;
            pass   <= pass + sstf_pkg::CNT_BITS'(1);
            rd_idx <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
